FILE: sv/plist_pkg.sv
package plist_pkg;

   // list geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths fixed by the interface
   localparam int KIND_W  = 2;
   localparam int POS_W   = 5;
   localparam int DATA_W  = 32;
   localparam int STS_W   = 2;
   localparam int OCNT_W  = 5;

   // compare width wide enough for both position and count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_DUMP   = 2'd2
   } plist_kind_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2,
      STS_EMPTY = 2'd3
   } plist_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } plist_state_type;

   // controller to datapath
   typedef struct packed {
      logic single;      // apply request and load its one result
      logic dump_start;  // clear the dump index
      logic dump_emit;   // load the entry at the dump index
   } plist_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dump_go;     // request is a dump of a non-empty list
      logic dump_last;   // dump index points at the final entry
   } plist_stat_type;

endpackage

FILE: sv/plist_if.sv
interface plist_req_if;
   import plist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        req_type;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, req_type, position, value, input ready);
   modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface plist_rsp_if;
   import plist_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STS_W-1:0]         status;
   logic signed [DATA_W-1:0] element;
   logic [OCNT_W-1:0]        count;
   logic                     last;

   modport source (output valid, status, element, count, last, input ready);
   modport sink   (input valid, status, element, count, last, output ready);
endinterface

FILE: sv/positional_list_insert_remove_top.sv
// channel   dir  handshake            payload
// req_if    in   valid / ready        req_type, position, value
// rsp_if    out  valid / ready        status, element, count, last
//
// insert, remove and any rejected request: the result is registered and offered in the cycle after the transfer
// dump: the transfer starts the walk, then one result per entry, one per cycle while the result register is free
//   or being drained, read from the cell chain at the dump index
// an insert or remove shifts all cells at and beyond the position at once
// reset (synchronous) empties the list; entry contents stay undefined
// a stalled result holds; a new request is taken as soon as the result
//   register is free or being drained, except while a dump runs
module positional_list_insert_remove_top
   import plist_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   plist_req_if.sink    req_if,
   plist_rsp_if.source  rsp_if
);

   plist_cmd_type  cmd;    // controller commands to the datapath
   plist_stat_type stat;   // request checks and dump progress back

   // sequencing: request acceptance, dump walk, result valid
   plist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // cell chain, entry count and the result register
   plist_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_if.req_type),
      .position    (req_if.position),
      .value       (req_if.value),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_if.status),
      .rsp_element (rsp_if.element),
      .rsp_count   (rsp_if.count),
      .rsp_last    (rsp_if.last)
   );

endmodule

FILE: sv/plist_ctrl.sv
module plist_ctrl
   import plist_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  plist_stat_type stat,
   output plist_cmd_type  cmd
);

   plist_state_type state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;
   logic            accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.dump_go) state_in = ST_DUMP;
         end
         ST_DUMP: begin
            if (out_free && stat.dump_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.single     = accept && !stat.dump_go;
            cmd.dump_start = accept && stat.dump_go;
         end
         ST_DUMP: begin
            cmd.dump_emit = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (cmd.single || cmd.dump_emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)              rsp_valid_in = 1'b0;
      else                             rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/plist_dp.sv
module plist_dp
   import plist_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [KIND_W-1:0]        req_type,
   input  logic [POS_W-1:0]         position,
   input  logic signed [DATA_W-1:0] value,
   input  plist_cmd_type            cmd,
   output plist_stat_type           stat,
   output logic [STS_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic [OCNT_W-1:0]        rsp_count,
   output logic                     rsp_last
);

   logic signed [DATA_W-1:0] entries_ff [CAPACITY];
   logic signed [DATA_W-1:0] entries_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;

   logic [STS_W-1:0]         status_ff, status_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic [OCNT_W-1:0]        ocount_ff, ocount_in;
   logic                     last_ff, last_in;

   logic [CMP_W-1:0]         pos_ext, cnt_ext;
   logic                     is_empty, is_full;
   logic                     do_ins, do_rem;
   logic [IDX_W-1:0]         cell_pos;
   plist_status_type         req_status;

   assign pos_ext  = CMP_W'(position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= CNT_W'(CAPACITY));

   // request checks
   always_comb begin
      req_status = STS_OK;
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      case (req_type)
         REQ_INSERT: begin
            if (is_full)                  req_status = STS_FULL;
            else if (is_empty)            do_ins = 1'b1;
            else if (pos_ext > cnt_ext)   req_status = STS_RANGE;
            else                          do_ins = 1'b1;
         end
         REQ_REMOVE: begin
            if (is_empty)                 req_status = STS_EMPTY;
            else if (pos_ext >= cnt_ext)  req_status = STS_RANGE;
            else                          do_rem = 1'b1;
         end
         REQ_DUMP: begin
            if (is_empty) req_status = STS_EMPTY;
         end
         default: req_status = STS_RANGE;
      endcase
   end

   // an insert into an empty list lands in entry 0
   assign cell_pos = is_empty ? '0 : IDX_W'(pos_ext);

   assign stat.dump_go   = (req_type == REQ_DUMP) && !is_empty;
   assign stat.dump_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // cell chain: every cell picks its neighbor, the new value or itself
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         if (cmd.single && do_ins) begin
            if (IDX_W'(i) == cell_pos) entries_in[i] = value;
            else if (IDX_W'(i) > cell_pos && i > 0)
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
         end else if (cmd.single && do_rem) begin
            if (IDX_W'(i) >= cell_pos && i < CAPACITY - 1)
               entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.single && do_ins)      count_in = count_ff + CNT_W'(1);
      else if (cmd.single && do_rem) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.dump_start)     idx_in = '0;
      else if (cmd.dump_emit) idx_in = idx_ff + IDX_W'(1);
   end

   // result register
   always_comb begin
      status_in  = status_ff;
      element_in = element_ff;
      ocount_in  = ocount_ff;
      last_in    = last_ff;
      if (cmd.single) begin
         status_in  = req_status;
         element_in = '0;
         ocount_in  = OCNT_W'(count_in);
         last_in    = 1'b1;
      end else if (cmd.dump_emit) begin
         status_in  = STS_OK;
         element_in = entries_ff[idx_ff];
         ocount_in  = OCNT_W'(count_ff);
         last_in    = stat.dump_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      status_ff  <= status_in;
      element_ff <= element_in;
      ocount_ff  <= ocount_in;
      last_ff    <= last_in;
   end

   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_count   = ocount_ff;
   assign rsp_last    = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.single |=> $stable(count_ff))
      else $error("entry count moved without a request");

   a_dump_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_emit |-> (CNT_W'(idx_ff) < count_ff))
      else $error("dump index past the last entry");

endmodule

FILE: bench/tb_positional_list_insert_remove_top.sv
`timescale 1ns / 1ps

module tb_positional_list_insert_remove_top;
   import plist_pkg::*;

   // request code the block does not define, answered with a range status
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

   localparam int CLK_HALF    = 4;
   localparam int RESET_LEN   = 9;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int REPORT_MAX  = 10;

   // one transfer on the result channel
   typedef struct packed {
      plist_status_type         status;
      logic signed [DATA_W-1:0] element;
      logic [OCNT_W-1:0]        count;
      logic                     last;
   } list_result_type;

   logic clock;
   logic reset;

   plist_req_if req_if ();
   plist_rsp_if rsp_if ();

   positional_list_insert_remove_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // shadow copy of the list, advanced at each accepted request
   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int                       list_len;

   // results the block still owes, oldest first
   list_result_type pending_results [$];
   list_result_type want;

   int          mismatch_count;
   int unsigned cycle_count;

   // idling knobs, in percent of cycles
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;

   // when nonzero the receiver keeps ready low until this counts down to zero
   int unsigned hold_left;

   // free-running clock, 8 ns period
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // -----------------------------------------------------------------
   // reference behavior
   // -----------------------------------------------------------------

   // queue one result; count reports the list length after the request
   function automatic void expect_result(plist_status_type st,
                                         logic signed [DATA_W-1:0] el,
                                         logic lst);
      list_result_type r;
      r.status  = st;
      r.element = el;
      r.count   = list_len[OCNT_W-1:0];
      r.last    = lst;
      pending_results.push_back(r);
   endfunction

   // apply one request to the shadow list and queue what it must return
   function automatic void apply_list_request(logic [KIND_W-1:0] kind,
                                              logic [POS_W-1:0] pos,
                                              logic signed [DATA_W-1:0] val);
      int i;
      case (kind)
         REQ_INSERT: begin
            // full check wins over the position check
            if (list_len >= CAPACITY) begin
               expect_result(STS_FULL, '0, 1'b1);
            end else if (list_len == 0) begin
               // empty list takes the value at any position
               list_mem[0] = val;
               list_len    = 1;
               expect_result(STS_OK, '0, 1'b1);
            end else if (pos > list_len) begin
               expect_result(STS_RANGE, '0, 1'b1);
            end else begin
               for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_len++;
               expect_result(STS_OK, '0, 1'b1);
            end
         end
         REQ_REMOVE: begin
            if (list_len == 0) begin
               expect_result(STS_EMPTY, '0, 1'b1);
            end else if (pos >= list_len) begin
               expect_result(STS_RANGE, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
               expect_result(STS_OK, '0, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (list_len == 0) begin
               expect_result(STS_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++)
                  expect_result(STS_OK, list_mem[i], i == list_len - 1);
            end
         end
         default: begin
            expect_result(STS_RANGE, '0, 1'b1);
         end
      endcase
   endfunction

   // -----------------------------------------------------------------
   // request side
   // -----------------------------------------------------------------

   // mostly random words, with the sign and all-ones corners mixed in
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // offer one request and return right after its transfer; valid stays
   // high so that a following call can go back to back
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         // idle cycles carry junk payload with valid low
         req_if.valid    <= 1'b0;
         req_if.req_type <= KIND_W'($urandom_range(3));
         req_if.position <= POS_W'($urandom_range(31));
         req_if.value    <= $urandom;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= kind;
      req_if.position <= pos;
      req_if.value    <= val;
      do @(posedge clock); while (!req_if.ready);
      apply_list_request(kind, pos, val);
   endtask

   // drop valid after the last transfer of a burst
   task automatic release_request();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // stop offering and wait until every owed result has been seen
   task automatic wait_until_drained();
      release_request();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // mostly legal positions for the current length, some dumps, some noise
   task automatic send_random_request();
      int unsigned       pick;
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      pick = $urandom_range(99);
      if (pick < 12) begin
         kind = KIND_W'($urandom_range(3));
         pos  = POS_W'($urandom_range(31));
      end else if (pick < 24) begin
         kind = REQ_DUMP;
         pos  = POS_W'($urandom_range(31));
      end else if ($urandom_range(CAPACITY) >= list_len) begin
         // inserts grow more likely as the list empties
         kind = REQ_INSERT;
         pos  = POS_W'($urandom_range(list_len));
      end else begin
         kind = REQ_REMOVE;
         pos  = POS_W'($urandom_range(list_len - 1));
      end
      send_request(kind, pos, pick_value());
   endtask

   // -----------------------------------------------------------------
   // result side
   // -----------------------------------------------------------------

   // ready driver, also counts down a forced hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("unexpected result: status %0d element %0d count %0d last %0d",
                        rsp_if.status, rsp_if.element, rsp_if.count, rsp_if.last);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.element !== want.element ||
                rsp_if.count !== want.count || rsp_if.last !== want.last) begin
               if (mismatch_count < REPORT_MAX)
                  $display("exp/act st %0d/%0d el %0d/%0d cnt %0d/%0d last %0d/%0d",
                           want.status, rsp_if.status, want.element, rsp_if.element,
                           want.count, rsp_if.count, want.last, rsp_if.last);
               mismatch_count++;
            end
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL positional_list_insert_remove_top");
         $finish;
      end
   end

   // -----------------------------------------------------------------
   // tests
   // -----------------------------------------------------------------

   // empty-list corners, then a short list with an undefined request code, range errors and a dump
   task automatic test_empty_list();
      send_request(REQ_DUMP, 5'd0, '0);
      send_request(REQ_REMOVE, 5'd0, '0);
      send_request(REQ_REMOVE, 5'd31, '1);
      // empty list accepts any position
      send_request(REQ_INSERT, 5'd31, 32'sh8000_0000);
      send_request(REQ_INSERT, 5'd5, 32'sh1234_5678);
      send_request(REQ_INSERT, 5'd1, 32'sh7fff_ffff);
      send_request(REQ_INSERT, 5'd0, '1);
      send_request(REQ_UNUSED, 5'd0, 32'sh5555_5555);
      send_request(REQ_REMOVE, 5'd3, '0);
      send_request(REQ_REMOVE, 5'd31, '0);
      send_request(REQ_DUMP, 5'd31, '0);
   endtask

   // fill to capacity at front, back and middle, then probe the full list
   task automatic test_full_list();
      logic [POS_W-1:0] pos;
      while (list_len < CAPACITY) begin
         case (list_len % 3)
            0:       pos = '0;
            1:       pos = POS_W'(list_len);
            default: pos = POS_W'(list_len / 2);
         endcase
         send_request(REQ_INSERT, pos, pick_value());
      end
      // full status even though the position is also bad
      send_request(REQ_INSERT, 5'd31, 32'sh0f0f_0f0f);
      send_request(REQ_DUMP, 5'd0, '0);
      send_request(REQ_REMOVE, 5'd16, '0);
      send_request(REQ_REMOVE, 5'd15, '0);
      send_request(REQ_REMOVE, 5'd0, '0);
   endtask

   // receiver stalls for a long stretch while requests keep coming, so the
   // result register fills and the request side must stall; then pause
   // until everything owed has arrived
   task automatic test_backpressure();
      int k;
      hold_left = 120;
      send_request(REQ_DUMP, 5'd0, '0);
      for (k = 0; k < 4; k++) send_request(REQ_INSERT, 5'd0, pick_value());
      send_request(REQ_DUMP, 5'd0, '0);
      send_request(REQ_REMOVE, 5'd2, '0);
      send_request(REQ_INSERT, 5'd31, pick_value());
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int unsigned send_pct,
                                      input int unsigned recv_pct,
                                      input int n_items);
      int k;
      send_idle_pct = send_pct;
      rsp_stall_pct = recv_pct;
      for (k = 0; k < n_items; k++) send_random_request();
   endtask

   // -----------------------------------------------------------------
   // main sequence
   // -----------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = '0;
      req_if.position = '0;
      req_if.value    = '0;
      list_len        = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      hold_left       = 0;
      send_idle_pct   = 17;
      rsp_stall_pct   = 75;

      repeat (RESET_LEN) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_full_list();
      test_backpressure();

      // busy sender with a slow receiver, then the reverse, then flat out
      test_random_traffic(17, 75, 35);
      test_random_traffic(75, 17, 35);
      test_random_traffic(0, 0, 30);

      wait_until_drained();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS positional_list_insert_remove_top");
      end else begin
         $display("FAIL positional_list_insert_remove_top");
      end
      $finish;
   end

endmodule
